[rtl/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants for the Hann smoothing filter.
// ----------------------------------------------------------------------------
package hsf_pkg;

  // Delay line depth and derived widths
  localparam int MAX_WINDOW = 1024;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WS_W       = 11;
  localparam int SIZE_W     = (PTR_W + 1 > WS_W) ? PTR_W + 1 : WS_W;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = 48;
  localparam int TOT_W    = 27;
  localparam int COEF_W   = 32;
  localparam int INV_W    = 31;
  localparam int DIFF_W   = 49;

  // Shared multiplier: operands split at SPLIT bits
  localparam int SPLIT  = 24;
  localparam int PP_A_W = 25;
  localparam int PP_B_W = 32;
  localparam int PP_W   = PP_A_W + PP_B_W;
  localparam int ACC_W  = 80;

  localparam int ROT_SHIFT = 30;
  localparam int OUT_SHIFT = 47;
  localparam int Y_W       = ACC_W - OUT_SHIFT;

  localparam logic [ACC_W-1:0] RND_ROT = ACC_W'(1) << (ROT_SHIFT - 1);
  localparam logic [ACC_W-1:0] RND_OUT = ACC_W'(1) << (OUT_SHIFT - 1);

  // APB register map
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_SIN_STEP    = 2'd1;
  localparam logic [1:0] REG_COS_STEP    = 2'd2;
  localparam logic [1:0] REG_INV_NORM    = 2'd3;

  localparam logic [WS_W-1:0]          RST_WINDOW_SIZE = WS_W'(128);
  localparam logic signed [COEF_W-1:0] RST_SIN_STEP    = -32'sd52281000;
  localparam logic signed [COEF_W-1:0] RST_COS_STEP    = 32'sd1072468500;
  localparam logic [INV_W-1:0]         RST_INV_NORM    = INV_W'(16647160);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [WS_W-1:0]          window_size;
    logic signed [COEF_W-1:0] sin_step;
    logic signed [COEF_W-1:0] cos_step;
    logic [INV_W-1:0]         inv_norm;
  } cfg_t;

  // Partial product selection for the shared multiplier
  typedef enum logic [3:0] {
    PP_SHI_COS,
    PP_SLO_COS,
    PP_CHI_SIN,
    PP_CLO_SIN,
    PP_SHI_SIN,
    PP_SLO_SIN,
    PP_CHI_COS,
    PP_CLO_COS,
    PP_DHI_INV,
    PP_DLO_INV
  } pp_sel_e;

  typedef struct packed {
    logic    load;       // item accepted: delay line access, phasor add
    logic    mul_en;     // launch partial product
    pp_sel_e mul_sel;
    logic    acc_add;    // accumulate registered partial product
    logic    acc_start;  // accumulator restarts from rounding constant
    logic    rnd_out;    // rounding constant of the output scaling
    logic    save_ns;    // capture rotated sine sum
    logic    commit;     // update sums and running total
    logic    diff_en;    // form total minus cosine sum
    logic    out_load;   // load saturated result
  } cmd_t;

endpackage

[rtl/hsf_in_if.sv]
// ----------------------------------------------------------------------------
// hsf_in_if
// Input sample channel: valid/ready handshake with one sample per item.
// ----------------------------------------------------------------------------
interface hsf_in_if;
  import hsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/hsf_out_if.sv]
// ----------------------------------------------------------------------------
// hsf_out_if
// Output sample channel: valid/ready handshake with one sample per item.
// ----------------------------------------------------------------------------
interface hsf_out_if;
  import hsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/hsf_regs.sv]
// ----------------------------------------------------------------------------
// hsf_regs
// APB configuration registers; a window size write restarts the filter.
// ----------------------------------------------------------------------------
module hsf_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsf_pkg::ADDR_W-1:0]   paddr,
  input  logic [hsf_pkg::DATA_W-1:0]   pwdata,
  output logic [hsf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output hsf_pkg::cfg_t                cfg_o,
  output logic                         clear_o
);
  import hsf_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign clear_o = wr_en && (reg_idx == REG_WINDOW_SIZE);
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size <= RST_WINDOW_SIZE;
      cfg_q.sin_step    <= RST_SIN_STEP;
      cfg_q.cos_step    <= RST_COS_STEP;
      cfg_q.inv_norm    <= RST_INV_NORM;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_SIZE: cfg_q.window_size <= pwdata[WS_W-1:0];
        REG_SIN_STEP:    cfg_q.sin_step    <= pwdata[COEF_W-1:0];
        REG_COS_STEP:    cfg_q.cos_step    <= pwdata[COEF_W-1:0];
        REG_INV_NORM:    cfg_q.inv_norm    <= pwdata[INV_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_SIZE: prdata = DATA_W'(cfg_q.window_size);
      REG_SIN_STEP:    prdata = cfg_q.sin_step;
      REG_COS_STEP:    prdata = cfg_q.cos_step;
      REG_INV_NORM:    prdata = DATA_W'(cfg_q.inv_norm);
    endcase
  end

endmodule

[rtl/hsf_ctrl.sv]
// ----------------------------------------------------------------------------
// hsf_ctrl
// Sequencer: steps the shared multiplier through the phasor rotation and
// the output scaling, then hands the result to the output register.
// ----------------------------------------------------------------------------
module hsf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hsf_pkg::cmd_t cmd_o
);
  import hsf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] STEP_FIRST = 4'd1;
  localparam logic [3:0] STEP_LAST  = 4'd14;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  cmd_t       cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    cmd.mul_sel = PP_SHI_COS;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          state_d  = ST_RUN;
          step_d   = STEP_FIRST;
        end
      end
      ST_RUN: begin
        step_d = step_q + 4'd1;
        // each partial product is accumulated in the step after its launch
        unique case (step_q)
          4'd1: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_SHI_COS;
          end
          4'd2: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_SLO_COS; cmd.acc_start = 1'b1;
          end
          4'd3: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_CHI_SIN; cmd.acc_add = 1'b1;
          end
          4'd4: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_CLO_SIN; cmd.acc_add = 1'b1;
          end
          4'd5: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_SHI_SIN; cmd.acc_add = 1'b1;
          end
          4'd6: begin
            cmd.mul_en  = 1'b1; cmd.mul_sel = PP_SLO_SIN; cmd.acc_start = 1'b1;
            cmd.save_ns = 1'b1;
          end
          4'd7: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_CHI_COS; cmd.acc_add = 1'b1;
          end
          4'd8: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_CLO_COS; cmd.acc_add = 1'b1;
          end
          4'd9:  cmd.acc_add = 1'b1;
          4'd10: cmd.commit  = 1'b1;
          4'd11: cmd.diff_en = 1'b1;
          4'd12: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = PP_DHI_INV;
          end
          4'd13: begin
            cmd.mul_en    = 1'b1; cmd.mul_sel = PP_DLO_INV;
            cmd.acc_start = 1'b1; cmd.rnd_out = 1'b1;
          end
          STEP_LAST: begin
            cmd.acc_add = 1'b1;
            state_d     = ST_DONE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/hsf_datapath.sv]
// ----------------------------------------------------------------------------
// hsf_datapath
// Delay line, phasor and running sums, one shared 25x32 multiplier with an
// 80-bit accumulator, and the saturating output register.
// ----------------------------------------------------------------------------
module hsf_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsf_pkg::cfg_t    cfg_i,
  input  logic             clear_i,
  input  hsf_pkg::cmd_t    cmd_i,
  input  hsf_pkg::sample_t sample_i,
  output hsf_pkg::sample_t sample_o
);
  import hsf_pkg::*;

  // Delay line
  logic [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] old_raw_q;
  logic                old_valid_q;
  logic [PTR_W-1:0]    wp_q;
  logic                wrapped_q;
  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   wp_inc;
  logic                wp_wrap;
  sample_t             old_s;

  // Sums
  sample_t                  x_q;
  logic signed [SUM_W-1:0]  cs_q, ss_q, c_q, ns_q;
  logic signed [TOT_W-1:0]  rt_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [SUM_W-1:0]  x_scaled, old_scaled;

  // Multiplier and accumulator
  logic signed [PP_A_W-1:0] a_op;
  logic signed [PP_B_W-1:0] b_op;
  logic                     pp_hi, pp_neg;
  logic signed [PP_W-1:0]   prod_q;
  logic                     pp_hi_q, pp_neg_q;
  logic [ACC_W-1:0]         acc_q, acc_base, prod_ext, term;
  logic signed [Y_W-1:0]    y;
  sample_t                  y_sat, out_q;

  always_comb begin
    if (cfg_i.window_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (SIZE_W'(cfg_i.window_size) > SIZE_W'(MAX_WINDOW)) begin
      size_eff = SIZE_W'(MAX_WINDOW);
    end else begin
      size_eff = SIZE_W'(cfg_i.window_size);
    end
  end

  assign wp_inc  = SIZE_W'(wp_q) + SIZE_W'(1);
  assign wp_wrap = (wp_inc >= size_eff);

  // Entries are written in order from zero after a clear, so until the first
  // wrap the slot about to be replaced has not been written and reads as zero.
  assign old_s = old_valid_q ? old_raw_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      old_raw_q      <= hist_mem[wp_q];
      hist_mem[wp_q] <= sample_i;
    end
  end

  assign x_scaled   = {{(SUM_W-SAMPLE_W-FRAC_W){sample_i[SAMPLE_W-1]}}, sample_i,
                       {FRAC_W{1'b0}}};
  assign old_scaled = {{(SUM_W-SAMPLE_W-FRAC_W){old_s[SAMPLE_W-1]}}, old_s,
                       {FRAC_W{1'b0}}};

  always_comb begin
    a_op   = '0;
    b_op   = '0;
    pp_hi  = 1'b0;
    pp_neg = 1'b0;
    unique case (cmd_i.mul_sel)
      PP_SHI_COS: begin
        a_op = {ss_q[SUM_W-1], ss_q[SUM_W-1:SPLIT]}; b_op = cfg_i.cos_step; pp_hi = 1'b1;
      end
      PP_SLO_COS: begin
        a_op = {1'b0, ss_q[SPLIT-1:0]}; b_op = cfg_i.cos_step;
      end
      PP_CHI_SIN: begin
        a_op = {c_q[SUM_W-1], c_q[SUM_W-1:SPLIT]}; b_op = cfg_i.sin_step;
        pp_hi = 1'b1; pp_neg = 1'b1;
      end
      PP_CLO_SIN: begin
        a_op = {1'b0, c_q[SPLIT-1:0]}; b_op = cfg_i.sin_step; pp_neg = 1'b1;
      end
      PP_SHI_SIN: begin
        a_op = {ss_q[SUM_W-1], ss_q[SUM_W-1:SPLIT]}; b_op = cfg_i.sin_step; pp_hi = 1'b1;
      end
      PP_SLO_SIN: begin
        a_op = {1'b0, ss_q[SPLIT-1:0]}; b_op = cfg_i.sin_step;
      end
      PP_CHI_COS: begin
        a_op = {c_q[SUM_W-1], c_q[SUM_W-1:SPLIT]}; b_op = cfg_i.cos_step; pp_hi = 1'b1;
      end
      PP_CLO_COS: begin
        a_op = {1'b0, c_q[SPLIT-1:0]}; b_op = cfg_i.cos_step;
      end
      PP_DHI_INV: begin
        a_op = diff_q[DIFF_W-1:SPLIT]; b_op = {1'b0, cfg_i.inv_norm}; pp_hi = 1'b1;
      end
      PP_DLO_INV: begin
        a_op = {1'b0, diff_q[SPLIT-1:0]}; b_op = {1'b0, cfg_i.inv_norm};
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q   <= a_op * b_op;
      pp_hi_q  <= pp_hi;
      pp_neg_q <= pp_neg;
    end
  end

  assign prod_ext = {{(ACC_W-PP_W){prod_q[PP_W-1]}}, prod_q};
  assign term     = pp_hi_q ? (prod_ext << SPLIT) : prod_ext;
  assign acc_base = cmd_i.acc_start ? (cmd_i.rnd_out ? RND_OUT : RND_ROT) : acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_add || cmd_i.acc_start) begin
      acc_q <= pp_neg_q ? (acc_base - term) : (acc_base + term);
    end
    if (cmd_i.save_ns) begin
      ns_q <= acc_q[ROT_SHIFT+SUM_W-1:ROT_SHIFT];
    end
    if (cmd_i.load) begin
      x_q <= sample_i;
      c_q <= cs_q + x_scaled;
    end
    if (cmd_i.diff_en) begin
      diff_q <= {{(DIFF_W-TOT_W-FRAC_W){rt_q[TOT_W-1]}}, rt_q, {FRAC_W{1'b0}}}
              - {cs_q[SUM_W-1], cs_q};
    end
    if (cmd_i.out_load) begin
      out_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      old_valid_q <= 1'b0;
      cs_q        <= '0;
      ss_q        <= '0;
      rt_q        <= '0;
    end else if (clear_i) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      old_valid_q <= 1'b0;
      cs_q        <= '0;
      ss_q        <= '0;
      rt_q        <= '0;
    end else begin
      if (cmd_i.load) begin
        old_valid_q <= wrapped_q;
        if (wp_wrap) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_inc[PTR_W-1:0];
        end
      end
      if (cmd_i.commit) begin
        ss_q <= ns_q;
        cs_q <= acc_q[ROT_SHIFT+SUM_W-1:ROT_SHIFT] - old_scaled;
        rt_q <= rt_q + {{(TOT_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q}
                     - {{(TOT_W-SAMPLE_W){old_s[SAMPLE_W-1]}}, old_s};
      end
    end
  end

  assign y = acc_q[ACC_W-1:OUT_SHIFT];

  // saturate when the sample's sign bit and the bits above it disagree
  always_comb begin
    if ((&y[Y_W-1:SAMPLE_W-1]) || !(|y[Y_W-1:SAMPLE_W-1])) begin
      y_sat = y[SAMPLE_W-1:0];
    end else if (y[Y_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign sample_o = out_q;

endmodule

[rtl/hann_smoothing_filter.sv]
// ----------------------------------------------------------------------------
// hann_smoothing_filter
// Hann-window smoothing of a Q15 sample stream in recursive phasor form.
// ----------------------------------------------------------------------------
// Flow: one item in flight; a new input item is taken only once the last
//   result is in the output register. The single shared 25x32 multiplier
//   computes ten partial products per item (eight rotation, two scaling).
// Reset: asynchronous, clears sums, write pointer and delay line state;
//   registers return to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module hann_smoothing_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hsf_in_if.sink                     in_if,
  hsf_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hsf_pkg::ADDR_W-1:0] paddr,
  input  logic [hsf_pkg::DATA_W-1:0] pwdata,
  output logic [hsf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hsf_pkg::*;

  cfg_t cfg;
  logic clear;
  cmd_t cmd;

  hsf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  hsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  hsf_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .clear_i  (clear),
    .cmd_i    (cmd),
    .sample_i (in_if.sample_in),
    .sample_o (out_if.sample_out)
  );

  // one item in flight: no new item right after one was taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while an item is in progress");

  // a result only appears through the output load
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

  // sequencer phases never overlap
  a_phases_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.commit, cmd.diff_en, cmd.out_load}))
    else $error("overlapping sequencer phases");

  // accumulator restart and plain accumulate are exclusive
  a_acc_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.acc_add && cmd.acc_start))
    else $error("accumulator add and restart together");

endmodule

[tb/hann_smoothing_filter_test.sv]
// ----------------------------------------------------------------------------
// hann_smoothing_filter_test
// Self-checking bench for the Hann smoothing filter. A bit-exact predictor
// tracks the delay line, phasor sums and running total and checks every
// output sample in order. A short table of directed items (pass-through and
// saturation settings, window limits, growing phasor) runs first. Random
// phases with fresh register settings and varied handshake idling follow.
// ----------------------------------------------------------------------------
module hann_smoothing_filter_test;
  import hsf_pkg::*;

  localparam int          N_PHASES     = 10;
  localparam int          DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 300;
  localparam real         PI           = 3.14159265358979323846;

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] Q30_NEG_ONE = 32'hC000_0000;
  localparam logic [31:0] INV_MAX     = 32'h7FFF_FFFF;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    sample_t     sample;
    logic        known;
    sample_t     want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  hsf_in_if  in_ch ();
  hsf_out_if out_ch ();

  hann_smoothing_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  cfg_t               model_cfg;
  sample_t            delay_line [MAX_WINDOW];
  int unsigned        line_ptr;
  logic signed [47:0] cos_acc;
  logic signed [47:0] sin_acc;
  logic signed [26:0] win_total;

  sample_t     smoothed_q [$];
  int          err_count = 0;
  int unsigned cycle_count = 0;

  int      in_idle_pct = 25;
  int      out_stall_pct = 25;
  int      hold_len = 0;
  int      hold_cnt = 0;
  logic    known_valid = 1'b0;
  sample_t known_value = '0;
  sample_t pred_s;
  sample_t want_s;

  function automatic int unsigned effective_window(input int unsigned n);
    if (n == 0) return 1;
    if (n > MAX_WINDOW) return MAX_WINDOW;
    return n;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < MAX_WINDOW; i++) delay_line[i] = '0;
    line_ptr  = 0;
    cos_acc   = '0;
    sin_acc   = '0;
    win_total = '0;
  endfunction

  function automatic void set_model_reg(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      REG_WINDOW_SIZE: begin
        model_cfg.window_size = val[WS_W-1:0];
        clear_model();
      end
      REG_SIN_STEP: model_cfg.sin_step = val;
      REG_COS_STEP: model_cfg.cos_step = val;
      REG_INV_NORM: model_cfg.inv_norm = val[INV_W-1:0];
      default: ;
    endcase
  endfunction

  // One step of the recursive Hann filter, bit exact
  function automatic sample_t smooth_sample(input sample_t x);
    logic signed [127:0] xw, ow, cw, sw, cs, sn, rs, rc, tw, dw, yw, acc;
    int unsigned size;
    sample_t old_s;
    size = effective_window(model_cfg.window_size);
    if (line_ptr >= size) line_ptr = 0;
    old_s = delay_line[line_ptr];
    delay_line[line_ptr] = x;
    line_ptr = (line_ptr + 1 >= size) ? 0 : line_ptr + 1;

    xw  = x;
    ow  = old_s;
    acc = cos_acc;
    acc = acc + (xw <<< 16);
    cw  = $signed(acc[47:0]);
    sw  = sin_acc;
    cs  = $signed(model_cfg.cos_step);
    sn  = $signed(model_cfg.sin_step);
    rs  = (sw * cs - cw * sn + (128'sd1 <<< 29)) >>> 30;
    rc  = (sw * sn + cw * cs + (128'sd1 <<< 29)) >>> 30;
    sin_acc = rs[47:0];
    acc     = rc - (ow <<< 16);
    cos_acc = acc[47:0];
    tw  = win_total;
    acc = tw + xw - ow;
    win_total = acc[26:0];

    tw  = win_total;
    cw  = cos_acc;
    dw  = (tw <<< 16) - cw;
    acc = {97'd0, model_cfg.inv_norm};
    yw  = (dw * acc + (128'sd1 <<< 46)) >>> 47;
    if (yw > 128'sd32767) return 16'sh7FFF;
    if (yw < -128'sd32768) return 16'sh8000;
    return yw[15:0];
  endfunction

  function automatic stim_row_t row_w(input logic [1:0] idx, input logic [31:0] val);
    return '{ROW_WRITE, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic stim_row_t row_s(input sample_t x);
    return '{ROW_SAMPLE, REG_WINDOW_SIZE, '0, x, 1'b0, '0};
  endfunction

  function automatic stim_row_t row_k(input sample_t x, input sample_t y);
    return '{ROW_SAMPLE, REG_WINDOW_SIZE, '0, x, 1'b1, y};
  endfunction

  function automatic sample_t next_sample();
    int unsigned r;
    r = $urandom_range(15);
    case (r)
      0:          return 16'sh7FFF;
      1:          return 16'sh8000;
      2, 3, 4, 5: return sample_t'(int'($urandom_range(511)) - 256);
      default:    return sample_t'($urandom());
    endcase
  endfunction

  // Sender: inputs change on the falling edge only
  task automatic push_sample(input sample_t v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    set_model_reg(idx, val);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_WINDOW_SIZE: want = {{(32-WS_W){1'b0}}, model_cfg.window_size};
      REG_SIN_STEP:    want = model_cfg.sin_step;
      REG_COS_STEP:    want = model_cfg.cos_step;
      default:         want = {1'b0, model_cfg.inv_norm};
    endcase
    if (prdata !== want) begin
      err_count++;
      $display("%0t: readback of register %0d: expected %h, got %h",
               $time, idx, want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Called on a falling edge; returns on a rising edge with nothing in flight
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_phase_config(input int ph);
    int unsigned n, n_eff;
    real ang;
    logic [31:0] s_v, c_v, i_v;
    longint r;
    if (ph == 4) n = MAX_WINDOW;
    else if (ph == 7) n = $urandom_range(1) ? 0 : $urandom_range(2047, MAX_WINDOW + 1);
    else if (ph == 2) n = $urandom_range(4, 1);
    else n = $urandom_range(48, 2);
    n_eff = effective_window(n);
    ang = -2.0 * PI / real'(n_eff + 1);
    s_v = int'($sin(ang) * 1073741824.0);
    c_v = int'($cos(ang) * 1073741824.0);
    i_v = int'(2147483648.0 / real'(n_eff + 1));
    if (ph == 8) begin
      // growing phasor: sums wrap
      s_v = Q30_NEG_ONE;
      c_v = Q30_ONE;
      i_v = INV_MAX;
    end else if (ph == 9) begin
      r   = longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824;
      s_v = r[31:0];
      r   = longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824;
      c_v = r[31:0];
      i_v = $urandom() & INV_MAX;
    end
    write_reg(REG_WINDOW_SIZE, n);
    write_reg(REG_SIN_STEP, s_v);
    write_reg(REG_COS_STEP, c_v);
    write_reg(REG_INV_NORM, i_v);
  endtask

  // Predict on every accepted input item
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pred_s = smooth_sample(in_ch.sample_in);
      smoothed_q.push_back(known_valid ? known_value : pred_s);
    end
  end

  // Check every accepted output item
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (smoothed_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected sample_out: expected none, got %0d",
                 $time, out_ch.sample_out);
      end else begin
        want_s = smoothed_q.pop_front();
        if (out_ch.sample_out !== want_s) begin
          err_count++;
          $display("%0t: sample_out mismatch: expected %0d, got %0d",
                   $time, want_s, out_ch.sample_out);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    int n_items;

    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    model_cfg = '{RST_WINDOW_SIZE, RST_SIN_STEP, RST_COS_STEP, RST_INV_NORM};
    clear_model();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Window 1 with cos -1, sin 0 and gain 1/2 passes samples straight through
    dir_rows = '{
      row_k(16'sh7FFF, 16'sd0),
      row_s(16'sh8000), row_s(16'sd0), row_s(16'sd1), row_s(-16'sd1),
      row_s(16'sh5555), row_s(16'shAAAA),
      row_w(REG_WINDOW_SIZE, 32'd1), row_w(REG_SIN_STEP, 32'd0),
      row_w(REG_COS_STEP, Q30_NEG_ONE), row_w(REG_INV_NORM, Q30_ONE),
      row_k(16'sh7FFF, 16'sh7FFF), row_k(16'sh8000, 16'sh8000),
      row_k(16'sd0, 16'sd0), row_k(16'sd1, 16'sd1), row_k(-16'sd1, -16'sd1),
      // full gain: extremes saturate
      row_w(REG_INV_NORM, INV_MAX),
      row_k(16'sh7FFF, 16'sh7FFF), row_k(16'sh8000, 16'sh8000),
      row_k(16'sd100, 16'sd200),
      row_w(REG_INV_NORM, 32'd0),
      row_k(16'sd12345, 16'sd0),
      // window zero acts as one
      row_w(REG_INV_NORM, Q30_ONE), row_w(REG_WINDOW_SIZE, 32'd0),
      row_k(-16'sd20000, -16'sd20000), row_k(16'sh7FFF, 16'sh7FFF),
      // oversized window, extreme coefficients
      row_w(REG_WINDOW_SIZE, 32'd2047), row_w(REG_SIN_STEP, Q30_ONE),
      row_w(REG_COS_STEP, Q30_ONE), row_w(REG_INV_NORM, INV_MAX),
      row_s(16'sh7FFF), row_s(16'sh8000), row_s(16'sh7FFF), row_s(16'sd0),
      row_w(REG_SIN_STEP, Q30_NEG_ONE),
      row_s(16'sd1234), row_s(16'sh7FFF)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        @(negedge clk_i);
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        known_valid = dir_rows[i].known;
        known_value = dir_rows[i].want;
        push_sample(dir_rows[i].sample);
        known_valid = 1'b0;
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 83; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 83; end
        default: begin in_idle_pct = 25; out_stall_pct = 25; end
      endcase
      if (ph == 0) hold_len = HOLD_CYCLES;
      @(negedge clk_i);
      apply_phase_config(ph);
      n_items = (ph == 4) ? MAX_WINDOW + 6 : 80;
      for (int k = 0; k < n_items; k++) push_sample(next_sample());
    end

    settle();
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[hann_smoothing_filter.f]
rtl/hsf_pkg.sv
rtl/hsf_in_if.sv
rtl/hsf_out_if.sv
rtl/hsf_regs.sv
rtl/hsf_ctrl.sv
rtl/hsf_datapath.sv
rtl/hann_smoothing_filter.sv
tb/hann_smoothing_filter_test.sv
